// ----- rtl/rbst_pkg.sv -----
// Package for the ray/box slab test: payload structs, register indexes,
// pipeline depths and the quotient saturation function.
// No dependencies.
package rbst_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int DIV_STEPS     = 32;
  localparam int DIV_LAT       = DIV_STEPS + 1;
  localparam int LANE_LAT      = DIV_LAT + 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Z = 3'd5;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [30:0]        ray_limit;
    logic signed [31:0] dir_z;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] origin_z;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_x;
  } ray_in_t;

  typedef struct packed {
    logic signed [31:0] exit_distance;
    logic signed [31:0] entry_distance;
    logic               hit;
  } slab_out_t;

  typedef struct packed {
    logic        vld;
    logic [1:0]  tag;
    logic [31:0] q_a;
    logic [31:0] q_b;
    logic        sat_a;
    logic        sat_b;
    logic        neg_a;
    logic        neg_b;
  } div_out_t;

  typedef struct packed {
    logic               vld;
    logic signed [31:0] near_d;
    logic signed [31:0] far_d;
  } lane_res_t;

  function automatic logic signed [31:0] sat_quot(input logic [31:0] q, input logic sat,
                                                  input logic neg);
    logic signed [31:0] res;
    if (neg) begin
      res = (sat || q > 32'h8000_0000) ? SAT_MIN : -$signed(q);
    end else begin
      res = (sat || q[31]) ? SAT_MAX : $signed(q);
    end
    return res;
  endfunction

endpackage

// ----- rtl/rbst_div_pipe.sv -----
// Pipelined restoring divider, two numerators over one shared divisor,
// one quotient bit per stage. Depends on rbst_pkg.
module rbst_div_pipe import rbst_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [1:0]         in_tag,
  input  logic signed [32:0] num_a,
  input  logic signed [32:0] num_b,
  input  logic signed [31:0] den,
  output div_out_t           res
);

  localparam int NW = 33 + FRAC_BITS;

  logic        vld_r   [0:DIV_STEPS];
  logic [1:0]  tag_r   [0:DIV_STEPS];
  logic        neg_a_r [0:DIV_STEPS];
  logic        neg_b_r [0:DIV_STEPS];
  logic [31:0] ad_r    [0:DIV_STEPS-1];
  logic [32:0] rem_a_r [0:DIV_STEPS-1];
  logic [32:0] rem_b_r [0:DIV_STEPS-1];
  logic [31:0] low_a_r [0:DIV_STEPS-1];
  logic [31:0] low_b_r [0:DIV_STEPS-1];
  logic [31:0] q_a_r   [1:DIV_STEPS];
  logic [31:0] q_b_r   [1:DIV_STEPS];
  logic        sat_a_r [1:DIV_STEPS];
  logic        sat_b_r [1:DIV_STEPS];

  logic [32:0]   an_a, an_b;
  logic [31:0]   ad;
  logic [NW-1:0] n_a, n_b;

  always_comb begin
    an_a = num_a[32] ? 33'(-num_a) : 33'(num_a);
    an_b = num_b[32] ? 33'(-num_b) : 33'(num_b);
    ad   = den[31] ? 32'(-den) : 32'(den);
    n_a  = {an_a, {FRAC_BITS{1'b0}}};
    n_b  = {an_b, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0]   <= in_tag;
    neg_a_r[0] <= num_a[32] ^ den[31];
    neg_b_r[0] <= num_b[32] ^ den[31];
    ad_r[0]    <= ad;
    rem_a_r[0] <= 33'(n_a[NW-1:32]);
    rem_b_r[0] <= 33'(n_b[NW-1:32]);
    low_a_r[0] <= n_a[31:0];
    low_b_r[0] <= n_b[31:0];
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [33:0] ta, tb, da, db;
    logic        bit_a, bit_b;
    logic [31:0] qa_prev, qb_prev;
    logic        sa_nxt, sb_nxt;

    always_comb begin
      ta    = {rem_a_r[k], low_a_r[k][DIV_STEPS-1-k]};
      tb    = {rem_b_r[k], low_b_r[k][DIV_STEPS-1-k]};
      da    = ta - {2'b00, ad_r[k]};
      db    = tb - {2'b00, ad_r[k]};
      bit_a = ~da[33];
      bit_b = ~db[33];
    end

    if (k == 0) begin : g_first
      assign qa_prev = '0;
      assign qb_prev = '0;
      assign sa_nxt  = rem_a_r[0] >= {1'b0, ad_r[0]};
      assign sb_nxt  = rem_b_r[0] >= {1'b0, ad_r[0]};
    end else begin : g_rest
      assign qa_prev = q_a_r[k];
      assign qb_prev = q_b_r[k];
      assign sa_nxt  = sat_a_r[k];
      assign sb_nxt  = sat_b_r[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      tag_r[k+1]   <= tag_r[k];
      neg_a_r[k+1] <= neg_a_r[k];
      neg_b_r[k+1] <= neg_b_r[k];
      q_a_r[k+1]   <= {qa_prev[30:0], bit_a};
      q_b_r[k+1]   <= {qb_prev[30:0], bit_b};
      sat_a_r[k+1] <= sa_nxt;
      sat_b_r[k+1] <= sb_nxt;
    end

    if (k < DIV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        ad_r[k+1]    <= ad_r[k];
        low_a_r[k+1] <= low_a_r[k];
        low_b_r[k+1] <= low_b_r[k];
        rem_a_r[k+1] <= bit_a ? da[32:0] : ta[32:0];
        rem_b_r[k+1] <= bit_b ? db[32:0] : tb[32:0];
      end
    end
  end

  always_comb begin
    res.vld   = vld_r[DIV_STEPS];
    res.tag   = tag_r[DIV_STEPS];
    res.q_a   = q_a_r[DIV_STEPS];
    res.q_b   = q_b_r[DIV_STEPS];
    res.sat_a = sat_a_r[DIV_STEPS];
    res.sat_b = sat_b_r[DIV_STEPS];
    res.neg_a = neg_a_r[DIV_STEPS];
    res.neg_b = neg_b_r[DIV_STEPS];
  end

`ifndef SYNTHESIS
  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> $past(in_vld, DIV_LAT))
    else $error("divider output without matching input");
`endif

endmodule

// ----- rtl/rbst_axis_lane.sv -----
// One axis lane: slab differences, pipelined division, saturation and
// near/far ordering with the zero-direction case. Depends on rbst_pkg, rbst_div_pipe.
module rbst_axis_lane import rbst_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [31:0] lo,
  input  logic signed [31:0] hi,
  input  logic signed [31:0] org,
  input  logic signed [31:0] dir,
  output lane_res_t          res
);

  logic               vld_r;
  logic signed [32:0] num_a_r, num_b_r;
  logic signed [31:0] den_r;
  logic [1:0]         tag_r;
  div_out_t           div_res;

  logic               q_vld_r;
  logic [1:0]         q_tag_r;
  logic signed [31:0] qa_r, qb_r;
  lane_res_t          res_r;
  lane_res_t          res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      q_vld_r <= 1'b0;
      res_r.vld <= 1'b0;
    end else begin
      vld_r   <= in_vld;
      q_vld_r <= div_res.vld;
      res_r.vld <= res_nxt.vld;
    end
  end

  // tag: {zero direction, origin inside slab}
  always_ff @(posedge clk) begin
    num_a_r <= 33'(lo) - 33'(org);
    num_b_r <= 33'(hi) - 33'(org);
    den_r   <= dir;
    tag_r   <= {dir == 32'sd0, (org >= lo) && (org <= hi)};
  end

  rbst_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (vld_r),
    .in_tag (tag_r),
    .num_a  (num_a_r),
    .num_b  (num_b_r),
    .den    (den_r),
    .res    (div_res)
  );

  always_ff @(posedge clk) begin
    q_tag_r <= div_res.tag;
    qa_r    <= sat_quot(div_res.q_a, div_res.sat_a, div_res.neg_a);
    qb_r    <= sat_quot(div_res.q_b, div_res.sat_b, div_res.neg_b);
  end

  always_comb begin
    res_nxt.vld = q_vld_r;
    if (q_tag_r[1]) begin
      res_nxt.near_d = q_tag_r[0] ? SAT_MIN : SAT_MAX;
      res_nxt.far_d  = q_tag_r[0] ? SAT_MAX : SAT_MIN;
    end else begin
      res_nxt.near_d = (qa_r < qb_r) ? qa_r : qb_r;
      res_nxt.far_d  = (qa_r < qb_r) ? qb_r : qa_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r.near_d <= res_nxt.near_d;
    res_r.far_d  <= res_nxt.far_d;
  end

  assign res = res_r;

endmodule

// ----- rtl/rbst_merge.sv -----
// Merge stage: largest near, smallest far over the three lanes, then the
// hit decision against zero and the ray limit. Depends on rbst_pkg.
module rbst_merge import rbst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  lane_res_t   lx,
  input  lane_res_t   ly,
  input  lane_res_t   lz,
  input  logic [30:0] limit,
  output logic        out_vld,
  output slab_out_t   out_res
);

  logic               vld_r;
  logic signed [31:0] entry_r, exit_r;
  logic [30:0]        limit_r;
  logic signed [31:0] entry_nxt, exit_nxt, lower;
  logic               out_vld_r;
  slab_out_t          out_r;

  always_comb begin
    entry_nxt = (lx.near_d > ly.near_d) ? lx.near_d : ly.near_d;
    if (lz.near_d > entry_nxt) begin
      entry_nxt = lz.near_d;
    end
    exit_nxt = (lx.far_d < ly.far_d) ? lx.far_d : ly.far_d;
    if (lz.far_d < exit_nxt) begin
      exit_nxt = lz.far_d;
    end
    lower = (entry_r > 32'sd0) ? entry_r : 32'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= lx.vld;
      out_vld_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r              <= entry_nxt;
    exit_r               <= exit_nxt;
    limit_r              <= limit;
    out_r.entry_distance <= entry_r;
    out_r.exit_distance  <= exit_r;
    out_r.hit            <= (exit_r >= lower) && (entry_r < $signed({1'b0, limit_r}));
  end

  assign out_vld = out_vld_r;
  assign out_res = out_r;

`ifndef SYNTHESIS
  a_hit_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && out_res.hit) |-> (out_res.exit_distance >= out_res.entry_distance))
    else $error("hit reported with exit before entry");
  a_hit_in_front: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && out_res.hit) |-> (out_res.exit_distance >= 32'sd0))
    else $error("hit reported with box behind origin");
`endif

endmodule

// ----- rtl/ray_box_slab_test_top.sv -----
// Ray versus axis-aligned box slab test, top level with box registers.
// Depends on rbst_pkg, rbst_axis_lane, rbst_merge.
//
// Usage:
//   Write the box corners through cfg_we/cfg_index/cfg_data (index 0..2 the
//   lower corner x/y/z, 3..5 the upper corner). Writes take effect at once.
//   A ray transaction is taken on each clock edge where start is high; busy
//   stays low, so one ray can be issued every cycle.
//   Each ray yields exactly one result: out_valid pulses for one cycle with
//   out_data once the ray has passed through all stages (1 input stage, 1 stage of
//   absolute values, 32 divider stages of one quotient bit each, 2 lane
//   stages, 2 merge stages). Up to 38 rays are in flight.
//   Throughput is one ray per cycle; the three axis lanes each hold a
//   fully pipelined divider shared by both slab planes of that axis.
//   The receiver cannot stall; results are shown once and not repeated.
//   Synchronous reset (rst_n low) clears the box to zero and drops every
//   ray in flight.
module ray_box_slab_test_top import rbst_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ray_in_t              in_data,
  output logic                 out_valid,
  output slab_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic signed [31:0] min_x_r, min_y_r, min_z_r;
  logic signed [31:0] max_x_r, max_y_r, max_z_r;
  logic               accept;
  logic [30:0]        lim_r [0:LANE_LAT-1];
  lane_res_t          lx, ly, lz;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= '0;
      min_y_r <= '0;
      min_z_r <= '0;
      max_x_r <= '0;
      max_y_r <= '0;
      max_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOX_MIN_X: min_x_r <= cfg_data;
        CFG_BOX_MIN_Y: min_y_r <= cfg_data;
        CFG_BOX_MIN_Z: min_z_r <= cfg_data;
        CFG_BOX_MAX_X: max_x_r <= cfg_data;
        CFG_BOX_MAX_Y: max_y_r <= cfg_data;
        CFG_BOX_MAX_Z: max_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // limit rides alongside the lanes
  always_ff @(posedge clk) begin
    lim_r[0] <= in_data.ray_limit;
    for (int i = 1; i < LANE_LAT; i++) begin
      lim_r[i] <= lim_r[i-1];
    end
  end

  rbst_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk (clk), .rst_n (rst_n), .in_vld (accept),
    .lo (min_x_r), .hi (max_x_r), .org (in_data.origin_x), .dir (in_data.dir_x),
    .res (lx)
  );

  rbst_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk (clk), .rst_n (rst_n), .in_vld (accept),
    .lo (min_y_r), .hi (max_y_r), .org (in_data.origin_y), .dir (in_data.dir_y),
    .res (ly)
  );

  rbst_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk (clk), .rst_n (rst_n), .in_vld (accept),
    .lo (min_z_r), .hi (max_z_r), .org (in_data.origin_z), .dir (in_data.dir_z),
    .res (lz)
  );

  rbst_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .lx      (lx),
    .ly      (ly),
    .lz      (lz),
    .limit   (lim_r[LANE_LAT-1]),
    .out_vld (out_valid),
    .out_res (out_data)
  );

`ifndef SYNTHESIS
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (lx.vld == ly.vld) && (lx.vld == lz.vld))
    else $error("axis lanes out of step");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LANE_LAT + 2))
    else $error("result without a ray transaction");
`endif

endmodule

// ----- bench/ray_box_slab_test_top_tb.sv -----
// Self-checking bench for ray_box_slab_test_top: drives ray transactions and box writes,
// predicts hit/entry/exit per ray and checks every result in order.
// Depends on rbst_pkg and the RTL of ray_box_slab_test_top.
`timescale 1ns / 1ps

class slab_scoreboard;
  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];
  rbst_pkg::slab_out_t pending_hits [$];
  int mismatches;

  function new();
    foreach (box_lo[i]) begin
      box_lo[i] = 0;
      box_hi[i] = 0;
    end
    mismatches = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      rbst_pkg::CFG_BOX_MIN_X: box_lo[0] = val;
      rbst_pkg::CFG_BOX_MIN_Y: box_lo[1] = val;
      rbst_pkg::CFG_BOX_MIN_Z: box_lo[2] = val;
      rbst_pkg::CFG_BOX_MAX_X: box_hi[0] = val;
      rbst_pkg::CFG_BOX_MAX_Y: box_hi[1] = val;
      rbst_pkg::CFG_BOX_MAX_Z: box_hi[2] = val;
      default: ;
    endcase
  endfunction

  function longint slab_quot(longint num, longint den);
    longint an, ad, q;
    bit neg;
    neg = (num < 0) != (den < 0);
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    q = (an <<< rbst_pkg::FRAC_BITS_DEF) / ad;
    if (neg) return (q > 64'sh8000_0000) ? -64'sh8000_0000 : -q;
    return (q > 64'sh7fff_ffff) ? 64'sh7fff_ffff : q;
  endfunction

  function void note_ray(rbst_pkg::ray_in_t r);
    longint entry, exitd, lo, hi, o, d, a, b, nr, fr, lower;
    rbst_pkg::slab_out_t e;
    entry = -64'sh8000_0000;
    exitd = 64'sh7fff_ffff;
    for (int k = 0; k < 3; k++) begin
      lo = box_lo[k];
      hi = box_hi[k];
      o = (k == 0) ? r.origin_x : (k == 1) ? r.origin_y : r.origin_z;
      d = (k == 0) ? r.dir_x : (k == 1) ? r.dir_y : r.dir_z;
      if (d == 0) begin
        if (o >= lo && o <= hi) begin
          nr = -64'sh8000_0000;
          fr = 64'sh7fff_ffff;
        end else begin
          nr = 64'sh7fff_ffff;
          fr = -64'sh8000_0000;
        end
      end else begin
        a = slab_quot(lo - o, d);
        b = slab_quot(hi - o, d);
        nr = a < b ? a : b;
        fr = a < b ? b : a;
      end
      if (nr > entry) entry = nr;
      if (fr < exitd) exitd = fr;
    end
    lower = entry > 0 ? entry : 0;
    e.hit = (exitd >= lower) && (entry < longint'(r.ray_limit));
    e.entry_distance = entry[31:0];
    e.exit_distance = exitd[31:0];
    pending_hits = {pending_hits, e};
  endfunction

  function void check_result(rbst_pkg::slab_out_t got);
    rbst_pkg::slab_out_t e;
    if (pending_hits.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    e = pending_hits.pop_front();
    if (got !== e) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch exp %p got %p", e, got);
    end
  endfunction
endclass

module ray_box_slab_test_top_tb;
  import rbst_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  ray_in_t in_data;
  logic out_valid;
  slab_out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  slab_scoreboard sb;
  int stall_cycles;
  logic signed [31:0] cur_lo [3];
  logic signed [31:0] cur_hi [3];

  ray_box_slab_test_top dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
    if (rst_n && ((start && !busy) || out_valid)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 5000) begin
      $display("FAIL ray_box_slab_test_top");
      $finish;
    end
  end

  task automatic write_box(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    while (sb.pending_hits.size() != 0) @(negedge clk);
    repeat (LANE_LAT + 10) @(negedge clk);
  endtask

  task automatic send_ray(ray_in_t r, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      @(negedge clk);
      start = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1;
    in_data = r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_ray(r);
  endtask

  task automatic idle_input();
    @(negedge clk);
    start = 0;
  endtask

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 2) == 0 ? 32'h0 : $urandom_range(0, 1) ? 32'h7fff_ffff
                : 32'h8000_0000;
      default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  function automatic ray_in_t random_ray();
    ray_in_t r;
    int m;
    m = $urandom_range(0, 9);
    r.origin_x = rnd_coord(m < 2 ? m : 2);
    r.origin_y = rnd_coord(m < 2 ? m : 2);
    r.origin_z = rnd_coord(m < 2 ? m : 2);
    r.dir_x = $urandom_range(0, 5) == 0 ? 32'h0 : rnd_coord(m < 2 ? m : 2);
    r.dir_y = $urandom_range(0, 5) == 0 ? 32'h0 : rnd_coord(m < 2 ? m : 2);
    r.dir_z = $urandom_range(0, 5) == 0 ? 32'h0 : rnd_coord(m < 2 ? m : 2);
    if (m >= 5) begin
      // aim roughly at the box center
      r.dir_x = ((cur_lo[0] >>> 1) + (cur_hi[0] >>> 1)) - (r.origin_x >>> 1)
                + $signed($urandom_range(0, 2048)) - 1024;
      r.dir_y = ((cur_lo[1] >>> 1) + (cur_hi[1] >>> 1)) - (r.origin_y >>> 1);
      r.dir_z = ((cur_lo[2] >>> 1) + (cur_hi[2] >>> 1)) - (r.origin_z >>> 1);
    end
    r.ray_limit = $urandom_range(0, 3) == 0 ? 31'($urandom)
                                             : 31'($urandom_range(0, 32'h0008_0000));
    return r;
  endfunction

  task automatic load_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                          logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
    idle_input();
    drain();
    write_box(CFG_BOX_MIN_X, lx);
    write_box(CFG_BOX_MIN_Y, ly);
    write_box(CFG_BOX_MIN_Z, lz);
    write_box(CFG_BOX_MAX_X, hx);
    write_box(CFG_BOX_MAX_Y, hy);
    write_box(CFG_BOX_MAX_Z, hz);
    cur_lo[0] = lx; cur_lo[1] = ly; cur_lo[2] = lz;
    cur_hi[0] = hx; cur_hi[1] = hy; cur_hi[2] = hz;
  endtask

  function automatic ray_in_t mk_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                     logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                     logic [30:0] lim);
    ray_in_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    r.ray_limit = lim;
    return r;
  endfunction

  initial begin
    logic [31:0] a, b;
    sb = new();
    rst_n = 0;
    start = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = CFG_BOX_MIN_X;
    cfg_data = 0;
    foreach (cur_lo[i]) begin
      cur_lo[i] = 0;
      cur_hi[i] = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send_ray(mk_ray(0, 0, 0, 0, 0, 0, 31'h10000), 0);
    load_box(32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
             32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_ray(mk_ray(32'hfffb_0000, 0, 0, 32'h0001_0000, 0, 0, 31'h7fff_ffff), 0);
    send_ray(mk_ray(32'hfffb_0000, 32'h0005_0000, 0, 32'h0001_0000, 0, 0, 31'h7fff_ffff), 0);
    send_ray(mk_ray(32'hfffb_0000, 0, 0, 32'h0001_0000, 0, 0, 31'h0001_0000), 0);
    send_ray(mk_ray(0, 0, 0, 32'hffff_0000, 32'h0000_8000, 32'h0000_0001, 0), 0);
    send_ray(mk_ray(32'h8000_0000, 32'h7fff_ffff, 0, 32'h0000_0001, 32'hffff_ffff,
                    32'h8000_0000, 31'h7fff_ffff), 0);
    send_ray(mk_ray(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                    32'h7fff_ffff, 32'h0, 31'h7fff_ffff), 0);
    send_ray(mk_ray(32'h0001_0000, 32'hffff_0000, 0, 0, 0, 32'h0001_0000, 31'h7fff_ffff), 0);
    send_ray(mk_ray(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'hffff_0000,
                    32'hffff_0000, 32'hffff_0000, 31'h0004_0000), 0);
    send_ray(mk_ray(0, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'h0), 0);
    load_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_ray(mk_ray(32'h7fff_ffff, 32'h8000_0000, 0, 32'h0000_0001, 32'hffff_ffff,
                    32'h0000_0001, 31'h7fff_ffff), 0);
    send_ray(mk_ray(0, 0, 0, 0, 0, 0, 31'h7fff_ffff), 0);
    load_box(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'hfffe_0000, 32'hfffe_0000,
             32'hfffe_0000);
    send_ray(mk_ray(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'h7fff_ffff), 0);
    send_ray(mk_ray(0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 31'h7fff_ffff), 0);

    for (int ph = 0; ph < 13; ph++) begin
      idle_input();
      case (ph % 4)
        0: load_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        1: load_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        default: begin
          a = $urandom_range(0, 32'h0008_0000);
          b = a + $urandom_range(1, 32'h0008_0000);
          load_box(a - 32'h0004_0000, a - 32'h0006_0000, a - 32'h0002_0000,
                   b - 32'h0004_0000, b - 32'h0003_0000, b);
        end
      endcase
      for (int i = 0; i < 150; i++) send_ray(random_ray(), (i / 40) % 2 == 0);
    end
    idle_input();
    drain();

    if (sb.mismatches == 0 && sb.pending_hits.size() == 0)
      $display("PASS ray_box_slab_test_top");
    else
      $display("FAIL ray_box_slab_test_top");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/rbst_pkg.sv
rtl/rbst_div_pipe.sv
rtl/rbst_axis_lane.sv
rtl/rbst_merge.sv
rtl/ray_box_slab_test_top.sv
bench/ray_box_slab_test_top_tb.sv
